// File: hw/rtl/mma_pkg.sv
package mma_pkg;

    // configuration port
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CORE_COUNT    = 4'd1;

    localparam logic [CFG_W-1:0] WINDOW_LENGTH_RESET = 4'd3;
    localparam logic [CFG_W-1:0] CORE_COUNT_RESET    = 4'd4;

    // controller to datapath
    typedef struct packed {
        logic stage;       // input transfer, latch sample into staging row
        logic commit;      // trim history, claim next ring slot
        logic copy;        // copy one staging entry into the ring
        logic rd;          // read one history entry for the sums
        logic start_all;   // divide total by cores * snapshots
        logic take_all;    // latch overall mean, rewind core counter
        logic start_core;  // divide current core sum by snapshots
        logic take_core;   // latch current core mean
        logic next_core;   // advance to next core
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic copy_last;
        logic rd_last;
        logic core_last;
        logic cores_zero;
        logic div_done;
    } t_sts;

endpackage

// File: hw/rtl/mma_div.sv
module mma_div #(
    parameter int W = 14
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quotient
);

    localparam int CNT_W = (W > 1) ? $clog2(W) : 1;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_quo;
    logic [W-1:0]     r_dsr;
    logic [W:0]       trial;
    logic             fits;

    // restoring division, one quotient bit per cycle
    assign trial = {r_rem, r_quo[W-1]};
    assign fits  = (trial >= {1'b0, r_dsr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (int'(r_cnt) == W - 1) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? W'(trial - {1'b0, r_dsr}) : W'(trial);
            r_quo <= {r_quo[W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: hw/rtl/mma_dp.sv
module mma_dp #(
    parameter  int MAX_CORES  = 8,
    parameter  int MAX_WINDOW = 10,
    parameter  int LOAD_BITS  = 7,
    localparam int CORE_W     = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mma_pkg::t_cmd              i_cmd,
    output mma_pkg::t_sts              o_sts,
    input  logic [mma_pkg::CFG_W-1:0]  i_window_length,
    input  logic [mma_pkg::CFG_W-1:0]  i_core_count,
    input  logic [CORE_W-1:0]          i_core_index,
    input  logic [LOAD_BITS-1:0]       i_load_value,
    output logic [CORE_W-1:0]          o_core_number,
    output logic [LOAD_BITS-1:0]       o_core_average,
    output logic [LOAD_BITS-1:0]       o_overall_average,
    output logic                       o_last_result
);

    localparam int SLOTS  = MAX_WINDOW + 1;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int DEPTH  = SLOTS * MAX_CORES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int HELD_W = $clog2(MAX_WINDOW + 2);
    localparam int SUM_W  = LOAD_BITS + $clog2(DEPTH);
    localparam int CFG_W  = mma_pkg::CFG_W;

    logic [LOAD_BITS-1:0] r_staging  [MAX_CORES];
    logic [LOAD_BITS-1:0] r_mem      [DEPTH];
    logic [SUM_W-1:0]     r_core_sum [MAX_CORES];

    logic [LOAD_BITS-1:0] r_rdata;
    logic [SLOT_W-1:0]    r_head;
    logic [SLOT_W-1:0]    r_wslot;
    logic [SLOT_W-1:0]    r_rslot;
    logic [HELD_W-1:0]    r_held;
    logic [HELD_W-1:0]    r_k;
    logic [CORE_W-1:0]    r_c;
    logic [CORE_W-1:0]    r_rd_c;
    logic                 r_rd_v;
    logic                 r_rd_end;
    logic [SUM_W-1:0]     r_acc;
    logic [SUM_W-1:0]     r_total;
    logic [LOAD_BITS-1:0] r_overall;
    logic [LOAD_BITS-1:0] r_core_avg;

    logic [CFG_W-1:0]     win;
    logic [CFG_W-1:0]     cores;
    logic [HELD_W-1:0]    held_trim;
    logic [SLOT_W-1:0]    head_inc;
    logic [SLOT_W-1:0]    rslot_dec;
    logic [ADDR_W-1:0]    wr_addr;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 last_k;
    logic                 copy_last;
    logic                 core_last;
    logic                 idx_ok;
    logic [SUM_W-1:0]     sum_in;
    logic [SUM_W-1:0]     div_dividend;
    logic [SUM_W-1:0]     div_divisor;
    logic [SUM_W-1:0]     div_quo;
    logic                 div_done;

    // out-of-range settings act as the largest supported value
    assign win   = (int'(i_window_length) > MAX_WINDOW) ? CFG_W'(MAX_WINDOW) : i_window_length;
    assign cores = (int'(i_core_count) > MAX_CORES) ? CFG_W'(MAX_CORES) : i_core_count;

    assign held_trim = (int'(r_held) > int'(win)) ? HELD_W'(win) : r_held;
    assign head_inc  = (int'(r_head) == SLOTS - 1) ? '0 : r_head + 1'b1;
    assign rslot_dec = (r_rslot == '0) ? SLOT_W'(SLOTS - 1) : r_rslot - 1'b1;
    assign wr_addr   = ADDR_W'(int'(r_wslot) * MAX_CORES + int'(r_c));
    assign rd_addr   = ADDR_W'(int'(r_rslot) * MAX_CORES + int'(r_c));
    assign last_k    = (int'(r_k) == int'(r_held) - 1);
    assign copy_last = (int'(r_c) == MAX_CORES - 1);
    assign core_last = (int'(r_c) == int'(cores) - 1);
    assign idx_ok    = (int'(i_core_index) < int'(cores));
    assign sum_in    = r_acc + SUM_W'(r_rdata);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_CORES; i++) begin
                r_staging[i] <= '0;
            end
            r_head  <= '0;
            r_wslot <= '0;
            r_rslot <= '0;
            r_held  <= '0;
            r_k     <= '0;
            r_c     <= '0;
            r_rd_v  <= 1'b0;
        end else begin
            r_rd_v <= i_cmd.rd;
            if (i_cmd.stage && idx_ok) begin
                r_staging[i_core_index] <= i_load_value;
            end
            if (i_cmd.commit) begin
                r_held  <= held_trim + 1'b1;
                r_wslot <= r_head;
                r_head  <= head_inc;
                r_c     <= '0;
            end
            if (i_cmd.copy) begin
                if (copy_last) begin
                    r_c     <= '0;
                    r_k     <= '0;
                    r_rslot <= r_wslot;
                end else begin
                    r_c <= r_c + 1'b1;
                end
            end
            // walk newest to oldest for each core in turn
            if (i_cmd.rd) begin
                if (last_k) begin
                    r_k     <= '0;
                    r_rslot <= r_wslot;
                    r_c     <= r_c + 1'b1;
                end else begin
                    r_k     <= r_k + 1'b1;
                    r_rslot <= rslot_dec;
                end
            end
            if (i_cmd.take_all) begin
                r_c <= '0;
            end
            if (i_cmd.next_core) begin
                r_c <= r_c + 1'b1;
            end
        end
    end

    // snapshot history
    always_ff @(posedge i_clk) begin
        if (i_cmd.copy) begin
            r_mem[wr_addr] <= r_staging[r_c];
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // sums and results
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_end <= last_k;
            r_rd_c   <= r_c;
        end
        if (i_cmd.copy && copy_last) begin
            r_acc   <= '0;
            r_total <= '0;
        end
        if (r_rd_v) begin
            if (r_rd_end) begin
                r_core_sum[r_rd_c] <= sum_in;
                r_total            <= r_total + sum_in;
                r_acc              <= '0;
            end else begin
                r_acc <= sum_in;
            end
        end
        if (i_cmd.take_all) begin
            r_overall <= div_quo[LOAD_BITS-1:0];
        end
        if (i_cmd.take_core) begin
            r_core_avg <= div_quo[LOAD_BITS-1:0];
        end
    end

    assign div_dividend = i_cmd.start_all ? r_total : r_core_sum[r_c];
    assign div_divisor  = i_cmd.start_all ? SUM_W'(int'(cores) * int'(r_held))
                                          : SUM_W'(r_held);

    mma_div #(
        .W (SUM_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start_all | i_cmd.start_core),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign o_sts.copy_last  = copy_last;
    assign o_sts.rd_last    = last_k & core_last;
    assign o_sts.core_last  = core_last;
    assign o_sts.cores_zero = (cores == '0);
    assign o_sts.div_done   = div_done;

    assign o_core_number     = r_c;
    assign o_core_average    = r_core_avg;
    assign o_overall_average = r_overall;
    assign o_last_result     = core_last;

endmodule

// File: hw/rtl/mma_ctrl.sv
module mma_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_end,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output mma_pkg::t_cmd o_cmd,
    input  mma_pkg::t_sts i_sts
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COPY,
        ST_SUM,
        ST_DRAIN,
        ST_ALL_GO,
        ST_ALL_WAIT,
        ST_CORE_GO,
        ST_CORE_WAIT,
        ST_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.stage = 1'b1;
                    if (i_in_end) begin
                        o_cmd.commit = 1'b1;
                        n_state      = ST_COPY;
                    end
                end
            end
            ST_COPY: begin
                o_cmd.copy = 1'b1;
                if (i_sts.copy_last) begin
                    n_state = i_sts.cores_zero ? ST_IDLE : ST_SUM;
                end
            end
            ST_SUM: begin
                o_cmd.rd = 1'b1;
                if (i_sts.rd_last) begin
                    n_state = ST_DRAIN;
                end
            end
            // last read word lands in the accumulator here
            ST_DRAIN: begin
                n_state = ST_ALL_GO;
            end
            ST_ALL_GO: begin
                o_cmd.start_all = 1'b1;
                n_state         = ST_ALL_WAIT;
            end
            ST_ALL_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.take_all = 1'b1;
                    n_state        = ST_CORE_GO;
                end
            end
            ST_CORE_GO: begin
                o_cmd.start_core = 1'b1;
                n_state          = ST_CORE_WAIT;
            end
            ST_CORE_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.take_core = 1'b1;
                    n_state         = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_out_ready) begin
                    if (i_sts.core_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.next_core = 1'b1;
                        n_state         = ST_CORE_GO;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_EMIT);

endmodule

// File: hw/rtl/multichannel_moving_average.sv
// Per-core moving average of load samples. Each sample transfer latches one
// active core's load into a staging row (an index at or past the core count is
// dropped); a transfer with i_snapshot_end set commits the row into a ring of
// MAX_WINDOW+1 snapshots (trimmed first to window_length) and then emits one
// result per active core, core 0 first, each carrying that core's floor mean
// and the floor mean over all active cores and held snapshots. The sums and
// the divider are SUM_W = LOAD_BITS + clog2((MAX_WINDOW+1)*MAX_CORES) bits
// wide, 14 at the defaults. The staging row is copied one entry a cycle, the
// history is summed through the single read port one entry a cycle, and every
// mean goes through one shared divider that makes one quotient bit a cycle.
// The block takes no sample until the last result of a commit has been taken.
module multichannel_moving_average #(
    parameter  int MAX_CORES  = 8,
    parameter  int MAX_WINDOW = 10,
    parameter  int LOAD_BITS  = 7,
    localparam int CORE_W     = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mma_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mma_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [CORE_W-1:0]             i_core_index,
    input  logic [LOAD_BITS-1:0]          i_load_value,
    input  logic                          i_snapshot_end,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [CORE_W-1:0]             o_core_number,
    output logic [LOAD_BITS-1:0]          o_core_average,
    output logic [LOAD_BITS-1:0]          o_overall_average,
    output logic                          o_last_result
);

    logic [mma_pkg::CFG_W-1:0] r_window_length;
    logic [mma_pkg::CFG_W-1:0] r_core_count;
    mma_pkg::t_cmd             cmd;
    mma_pkg::t_sts             sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= mma_pkg::WINDOW_LENGTH_RESET;
            r_core_count    <= mma_pkg::CORE_COUNT_RESET;
        end else if (i_cfg_we) begin
            priority if (i_cfg_index == mma_pkg::REG_WINDOW_LENGTH) begin
                r_window_length <= i_cfg_data;
            end else if (i_cfg_index == mma_pkg::REG_CORE_COUNT) begin
                r_core_count <= i_cfg_data;
            end else begin
                // unknown index, write dropped
                r_core_count <= r_core_count;
            end
        end
    end

    mma_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_end    (i_snapshot_end),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    mma_dp #(
        .MAX_CORES  (MAX_CORES),
        .MAX_WINDOW (MAX_WINDOW),
        .LOAD_BITS  (LOAD_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_window_length   (r_window_length),
        .i_core_count      (r_core_count),
        .i_core_index      (i_core_index),
        .i_load_value      (i_load_value),
        .o_core_number     (o_core_number),
        .o_core_average    (o_core_average),
        .o_overall_average (o_overall_average),
        .o_last_result     (o_last_result)
    );

endmodule

// File: hw/rtl/mma_chk.sv
module mma_chk #(
    parameter  int MAX_CORES  = 8,
    parameter  int LOAD_BITS  = 7,
    localparam int CORE_W     = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic                          i_snapshot_end,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [CORE_W-1:0]             o_core_number,
    input logic [LOAD_BITS-1:0]          o_core_average,
    input logic [LOAD_BITS-1:0]          o_overall_average,
    input logic                          o_last_result
);

    // a waiting result holds still
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_core_number)
            && $stable(o_core_average) && $stable(o_overall_average))
        else $error("result changed while stalled");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("sample taken while a result is pending");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown right after reset");

    // each further core needs a divide before its result
    a_gap_between: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_result |=> !o_valid)
        else $error("back-to-back results within a commit");

    a_plain_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && !i_snapshot_end |=> o_ready)
        else $error("non-committing transfer stalled the input");

endmodule

bind multichannel_moving_average mma_chk #(
    .MAX_CORES  (MAX_CORES),
    .LOAD_BITS  (LOAD_BITS)
) u_mma_chk (.*);

// File: tb/multichannel_moving_average_tb.sv
`timescale 1ns / 100ps

module multichannel_moving_average_tb;

    localparam int N_CORES       = 8;
    localparam int N_WINDOW      = 10;
    localparam int LOAD_W        = 7;
    localparam int CORE_W        = 3;
    localparam int RING_SLOTS    = N_WINDOW + 1;
    localparam int ITEM_TARGET   = 460;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 64;
    localparam int CYCLE_LIMIT   = 2_000_000;

    // index past the register list, writes to it must be dropped
    localparam logic [mma_pkg::CFG_IDX_W-1:0] REG_UNUSED = 4'hF;

    typedef struct packed {
        logic [CORE_W-1:0] core_number;
        logic [LOAD_W-1:0] core_average;
        logic [LOAD_W-1:0] overall_average;
        logic              last_result;
    } t_avg_result;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [mma_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [mma_pkg::CFG_W-1:0]     i_cfg_data;
    logic                          i_valid;
    logic                          o_ready;
    logic [CORE_W-1:0]             i_core_index;
    logic [LOAD_W-1:0]             i_load_value;
    logic                          i_snapshot_end;
    logic                          o_valid;
    logic                          i_ready;
    logic [CORE_W-1:0]             o_core_number;
    logic [LOAD_W-1:0]             o_core_average;
    logic [LOAD_W-1:0]             o_overall_average;
    logic                          o_last_result;

    multichannel_moving_average #(
        .MAX_CORES  (N_CORES),
        .MAX_WINDOW (N_WINDOW),
        .LOAD_BITS  (LOAD_W)
    ) uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_core_index      (i_core_index),
        .i_load_value      (i_load_value),
        .i_snapshot_end    (i_snapshot_end),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_core_number     (o_core_number),
        .o_core_average    (o_core_average),
        .o_overall_average (o_overall_average),
        .o_last_result     (o_last_result)
    );

    // predictor state
    logic [LOAD_W-1:0]         hist_loads [RING_SLOTS][N_CORES];
    logic [LOAD_W-1:0]         row_loads  [N_CORES];
    int                        ring_slot;
    int                        held_count;
    logic [mma_pkg::CFG_W-1:0] window_reg;
    logic [mma_pkg::CFG_W-1:0] cores_reg;

    t_avg_result pending_averages [$];

    int  fail_count;
    int  samples_sent;
    int  commits_sent;
    int  results_seen;
    int  settings_used;
    int  rx_hold_len;
    int  cycle_count;
    bit  tx_gaps_on;
    bit  rx_stalls_on;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("run stopped at the cycle limit, %0d results outstanding",
                 pending_averages.size());
        $display("Verification failed");
        $finish;
    end

    function automatic int active_cores();
        return (cores_reg > N_CORES) ? N_CORES : int'(cores_reg);
    endfunction

    function automatic void model_reset();
        for (int s = 0; s < RING_SLOTS; s++) begin
            for (int c = 0; c < N_CORES; c++) begin
                hist_loads[s][c] = '0;
            end
        end
        for (int c = 0; c < N_CORES; c++) begin
            row_loads[c] = '0;
        end
        ring_slot  = 0;
        held_count = 0;
        window_reg = mma_pkg::WINDOW_LENGTH_RESET;
        cores_reg  = mma_pkg::CORE_COUNT_RESET;
    endfunction

    function automatic void predict_averages(input logic [CORE_W-1:0] idx,
                                             input logic [LOAD_W-1:0] load,
                                             input logic snap_end);
        int cores;
        int win;
        int total;
        int sum;
        t_avg_result r;
        cores = active_cores();
        win   = (window_reg > N_WINDOW) ? N_WINDOW : int'(window_reg);
        if (idx < cores) begin
            row_loads[idx] = load;
        end
        if (!snap_end) begin
            return;
        end
        commits_sent++;
        // trim first, then append, so win+1 snapshots can be held
        if (held_count > win) begin
            held_count = win;
        end
        for (int c = 0; c < N_CORES; c++) begin
            hist_loads[ring_slot][c] = row_loads[c];
        end
        ring_slot = (ring_slot + 1) % RING_SLOTS;
        held_count++;
        total = 0;
        for (int c = 0; c < cores; c++) begin
            for (int k = 1; k <= held_count; k++) begin
                total += hist_loads[(ring_slot + RING_SLOTS - k) % RING_SLOTS][c];
            end
        end
        for (int c = 0; c < cores; c++) begin
            sum = 0;
            for (int k = 1; k <= held_count; k++) begin
                sum += hist_loads[(ring_slot + RING_SLOTS - k) % RING_SLOTS][c];
            end
            r.core_number     = CORE_W'(c);
            r.core_average    = LOAD_W'(sum / held_count);
            r.overall_average = LOAD_W'(total / (cores * held_count));
            r.last_result     = (c == cores - 1);
            pending_averages.push_back(r);
        end
    endfunction

    // result side: check each transfer, then pick the next ready level
    initial begin
        int stall_left;
        int hold_left;
        int pick;
        t_avg_result want;
        stall_left = 0;
        hold_left  = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                results_seen++;
                if (pending_averages.size() == 0) begin
                    $error("unexpected result for core %0d", o_core_number);
                    fail_count++;
                end else begin
                    want = pending_averages.pop_front();
                    if (o_core_number !== want.core_number) begin
                        $error("core_number: expected %0d, got %0d",
                               want.core_number, o_core_number);
                        fail_count++;
                    end
                    if (o_core_average !== want.core_average) begin
                        $error("core_average: expected %0d, got %0d",
                               want.core_average, o_core_average);
                        fail_count++;
                    end
                    if (o_overall_average !== want.overall_average) begin
                        $error("overall_average: expected %0d, got %0d",
                               want.overall_average, o_overall_average);
                        fail_count++;
                    end
                    if (o_last_result !== want.last_result) begin
                        $error("last_result: expected %0d, got %0d",
                               want.last_result, o_last_result);
                        fail_count++;
                    end
                end
            end
            if (rx_hold_len != 0) begin
                hold_left   = rx_hold_len;
                rx_hold_len = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (rx_stalls_on) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 2) begin
                        stall_left = $urandom_range(20, 60);
                    end else if (pick < 22) begin
                        stall_left = $urandom_range(1, 3);
                    end
                end
            end
        end
    end

    task automatic idle_gap();
        int pick;
        int len;
        if (!tx_gaps_on) begin
            return;
        end
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            len = 0;
        end else if (pick < 90) begin
            len = $urandom_range(1, 3);
        end else begin
            len = $urandom_range(8, 30);
        end
        if (len > 0) begin
            i_valid <= 1'b0;
            repeat (len) @(posedge i_clk);
        end
    endtask

    task automatic send_sample(input logic [CORE_W-1:0] idx, input logic [LOAD_W-1:0] load,
                               input logic snap_end);
        // samples for inactive cores without a commit do nothing
        if (snap_end || idx < active_cores()) begin
            samples_sent++;
        end
        i_valid        <= 1'b1;
        i_core_index   <= idx;
        i_load_value   <= load;
        i_snapshot_end <= snap_end;
        do @(posedge i_clk); while (!o_ready);
        predict_averages(idx, load, snap_end);
        idle_gap();
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_averages.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [mma_pkg::CFG_IDX_W-1:0] index,
                             input logic [mma_pkg::CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (index == mma_pkg::REG_WINDOW_LENGTH) begin
            window_reg = data;
        end else if (index == mma_pkg::REG_CORE_COUNT) begin
            cores_reg = data;
        end
        settings_used++;
    endtask

    function automatic logic [LOAD_W-1:0] random_load();
        if ($urandom_range(0, 99) < 3) begin
            return LOAD_W'($urandom_range(101, 127));
        end
        return LOAD_W'($urandom_range(0, 100));
    endfunction

    // one snapshot: active cores in random order, some skipped, a few strays
    task automatic send_snapshot();
        logic [CORE_W-1:0] order [N_CORES];
        logic [CORE_W-1:0] picked [$];
        logic [CORE_W-1:0] tmp;
        int cores;
        int j;
        cores = active_cores();
        for (int i = 0; i < N_CORES; i++) begin
            order[i] = CORE_W'(i);
        end
        for (int i = N_CORES - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < N_CORES; i++) begin
            if (order[i] < cores) begin
                if ($urandom_range(0, 99) < 85) begin
                    picked.push_back(order[i]);
                end
            end else if ($urandom_range(0, 99) < 10) begin
                picked.push_back(order[i]);
            end
        end
        if (picked.size() == 0) begin
            picked.push_back(CORE_W'($urandom_range(0, N_CORES - 1)));
        end
        for (int i = 0; i < picked.size(); i++) begin
            send_sample(picked[i], random_load(), i == picked.size() - 1);
        end
    endtask

    task automatic test_default_settings();
        send_sample(3'd0, 7'd0, 1'b0);
        send_sample(3'd1, 7'd127, 1'b0);
        send_sample(3'd2, 7'd100, 1'b0);
        send_sample(3'd3, 7'd1, 1'b1);
        // inactive core is dropped, cores 0..2 keep their earlier loads
        send_sample(3'd5, 7'd77, 1'b0);
        send_sample(3'd3, 7'd50, 1'b1);
        // inactive core still commits
        send_sample(3'd7, 7'd127, 1'b1);
        send_sample(3'd0, 7'd64, 1'b0);
        send_sample(3'd2, 7'd33, 1'b1);
        send_sample(3'd1, 7'd99, 1'b1);
        send_sample(3'd6, 7'd0, 1'b1);
        drain_results();
    endtask

    task automatic test_register_extremes();
        // zero window keeps only the newest snapshot
        write_reg(mma_pkg::REG_WINDOW_LENGTH, 4'd0);
        write_reg(mma_pkg::REG_CORE_COUNT, 4'd8);
        send_sample(3'd4, 7'd100, 1'b0);
        send_sample(3'd6, 7'd55, 1'b0);
        send_sample(3'd7, 7'd127, 1'b1);
        send_sample(3'd0, 7'd1, 1'b1);
        drain_results();
        // values past the maximum clamp
        write_reg(mma_pkg::REG_WINDOW_LENGTH, 4'd15);
        write_reg(mma_pkg::REG_CORE_COUNT, 4'd15);
        send_sample(3'd7, 7'd3, 1'b0);
        send_sample(3'd5, 7'd126, 1'b1);
        send_sample(3'd2, 7'd100, 1'b1);
        drain_results();
        // no active cores: commits happen silently
        write_reg(mma_pkg::REG_WINDOW_LENGTH, 4'd10);
        write_reg(mma_pkg::REG_CORE_COUNT, 4'd0);
        send_sample(3'd0, 7'd50, 1'b1);
        send_sample(3'd3, 7'd20, 1'b1);
        drain_results();
        write_reg(mma_pkg::REG_WINDOW_LENGTH, 4'd1);
        write_reg(mma_pkg::REG_CORE_COUNT, 4'd1);
        write_reg(REG_UNUSED, 4'hF);
        send_sample(3'd0, 7'd42, 1'b1);
        send_sample(3'd0, 7'd43, 1'b1);
        send_sample(3'd1, 7'd9, 1'b1);
        drain_results();
    endtask

    // a long receiver hold stalls the first results while samples are sent with no gaps
    task automatic test_output_backpressure();
        write_reg(mma_pkg::REG_WINDOW_LENGTH, 4'd4);
        write_reg(mma_pkg::REG_CORE_COUNT, 4'd8);
        tx_gaps_on  = 1'b0;
        rx_hold_len = 300;
        repeat (4) send_snapshot();
        tx_gaps_on = 1'b1;
        drain_results();
    endtask

    task automatic test_random_traffic();
        logic [mma_pkg::CFG_W-1:0] win_pick [5]   = '{4'd1, 4'd10, 4'd0, 4'd15, 4'd2};
        logic [mma_pkg::CFG_W-1:0] cores_pick [5] = '{4'd1, 4'd8, 4'd5, 4'd15, 4'd3};
        logic [mma_pkg::CFG_W-1:0] win;
        logic [mma_pkg::CFG_W-1:0] cores;
        int phase;
        int phase_end;
        phase = 0;
        while (samples_sent < ITEM_TARGET) begin
            if (phase < 5) begin
                win   = win_pick[phase];
                cores = cores_pick[phase];
            end else begin
                win   = ($urandom_range(0, 99) < 80)
                        ? mma_pkg::CFG_W'($urandom_range(1, 10))
                        : mma_pkg::CFG_W'($urandom_range(0, 15));
                cores = ($urandom_range(0, 99) < 85)
                        ? mma_pkg::CFG_W'($urandom_range(1, 8))
                        : mma_pkg::CFG_W'($urandom_range(0, 15));
            end
            write_reg(mma_pkg::REG_WINDOW_LENGTH, win);
            write_reg(mma_pkg::REG_CORE_COUNT, cores);
            tx_gaps_on   = ($urandom_range(0, 3) != 0);
            rx_stalls_on = ($urandom_range(0, 3) != 0);
            phase_end    = samples_sent + $urandom_range(40, 70);
            while (samples_sent < phase_end && samples_sent < ITEM_TARGET) begin
                if ($urandom_range(0, 99) < 85) begin
                    send_snapshot();
                end else begin
                    send_sample(CORE_W'($urandom_range(0, N_CORES - 1)),
                                LOAD_W'($urandom_range(0, 127)),
                                $urandom_range(0, 3) == 0);
                end
            end
            drain_results();
            phase++;
        end
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_index    <= '0;
        i_cfg_data     <= '0;
        i_valid        <= 1'b0;
        i_core_index   <= '0;
        i_load_value   <= '0;
        i_snapshot_end <= 1'b0;
        fail_count    = 0;
        samples_sent  = 0;
        commits_sent  = 0;
        results_seen  = 0;
        settings_used = 0;
        rx_hold_len   = 0;
        tx_gaps_on    = 1'b1;
        rx_stalls_on  = 1'b1;
        model_reset();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_settings();
        test_register_extremes();
        test_output_backpressure();
        test_random_traffic();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("sent %0d samples with %0d commits over %0d register writes",
                 samples_sent, commits_sent, settings_used);
        $display("checked %0d per-core averages, %0d mismatches", results_seen, fail_count);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/mma_pkg.sv
hw/rtl/mma_div.sv
hw/rtl/mma_dp.sv
hw/rtl/mma_ctrl.sv
hw/rtl/multichannel_moving_average.sv
hw/rtl/mma_chk.sv
tb/multichannel_moving_average_tb.sv
